// ----- rtl/nsrc_pkg.sv -----
// Package for the nearest sample rate converter.
// Holds the controller state type, the register indexes and the
// command/status structs shared by the controller and the datapath.
package nsrc_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegStepIncrement = 2'd0;
  localparam logic [1:0] RegSampleWidth   = 2'd1;
  localparam logic [1:0] RegOutputTotal   = 2'd2;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned StepW     = 12;
  localparam int unsigned CountW    = 24;
  localparam int unsigned PosW      = 32;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned OffsetW   = 10;

  // At most this many outputs come from one input.
  localparam int unsigned MaxRun  = 64;
  localparam int unsigned RunCntW = 6;

  localparam logic [StepW-1:0] StepReset = 12'd256;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // latch an input item
    logic emit;    // produce one output and advance the position
    logic finish;  // the current input is done; advance the input index
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_ok;    // the current input is repeated at least once more
    logic run_last;  // the output about to be made is the last for this input
    logic out_free;  // the output register can take a new result
  } sts_t;

endpackage

// ----- rtl/nsrc_ctrl.sv -----
// Controller state machine of the nearest sample rate converter.
// Depends on nsrc_pkg for the state type and the command/status structs.
module nsrc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  nsrc_pkg::sts_t sts_i,
  output nsrc_pkg::cmd_t cmd_o
);

  nsrc_pkg::state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    unique case (state_q)
      nsrc_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = nsrc_pkg::StRun;
        end
      end
      nsrc_pkg::StRun: begin
        if (!sts_i.run_ok) begin
          cmd_o.finish = 1'b1;
          state_d      = nsrc_pkg::StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.run_last) begin
            cmd_o.finish = 1'b1;
            state_d      = nsrc_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = nsrc_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nsrc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/nsrc_datapath.sv -----
// Datapath of the nearest sample rate converter: configuration registers,
// read position, counters, chunk counter and the output register.
// Depends on nsrc_pkg for widths, register indexes and command/status structs.
module nsrc_datapath #(
  parameter int unsigned CHUNK_SIZE = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [nsrc_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [nsrc_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic [nsrc_pkg::SampleW-1:0]        sample_raw_i,
  input  logic                                start_of_sound_i,
  input  nsrc_pkg::cmd_t                      cmd_i,
  output nsrc_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [nsrc_pkg::SampleW-1:0] sample_out_o,
  output logic                                chunk_start_o,
  output logic [nsrc_pkg::OffsetW-1:0]        chunk_offset_o,
  output logic                                run_last_o,
  output logic                                sound_done_o
);

  localparam int unsigned ChunkW = (CHUNK_SIZE > 2) ? $clog2(CHUNK_SIZE) : 1;
  localparam logic [ChunkW-1:0] ChunkLast = ChunkW'(CHUNK_SIZE - 1);

  logic [nsrc_pkg::StepW-1:0]   step_q;
  logic                         width_q;
  logic [nsrc_pkg::CountW-1:0]  total_q;

  logic [nsrc_pkg::PosW-1:0]    pos_q;
  logic [nsrc_pkg::CountW-1:0]  idx_q;
  logic [nsrc_pkg::CountW-1:0]  emitted_q;
  logic [ChunkW-1:0]            chunk_q;
  logic [nsrc_pkg::RunCntW-1:0] run_q;
  logic [nsrc_pkg::SampleW-1:0] sample_q;

  logic                         out_valid_q;
  logic [nsrc_pkg::SampleW-1:0] out_sample_q;
  logic                         out_start_q;
  logic [nsrc_pkg::OffsetW-1:0] out_offset_q;
  logic                         out_last_q;
  logic                         out_done_q;

  logic [nsrc_pkg::PosW-1:0]    pos_next;
  logic [nsrc_pkg::CountW-1:0]  emitted_next;
  logic [31:0]                  chunk_wide;
  logic [nsrc_pkg::SampleW-1:0] sample_conv;

  assign pos_next     = pos_q + nsrc_pkg::PosW'(step_q);
  assign emitted_next = emitted_q + nsrc_pkg::CountW'(1);
  assign chunk_wide   = 32'(chunk_q);

  // Unsigned bytes are recentred by flipping the top bit and moved to the top byte.
  assign sample_conv = width_q ? sample_raw_i : {sample_raw_i[7:0] ^ 8'h80, 8'h00};

  // The run continues while the position's integer part points at this input and outputs remain,
  // so the last output is known from the position after this step, the run cap or the total.
  assign sts_o.run_ok   = (pos_q[nsrc_pkg::PosW-1:8] == idx_q) && (emitted_q < total_q);
  assign sts_o.run_last = (run_q == nsrc_pkg::RunCntW'(nsrc_pkg::MaxRun - 1)) ||
                          !(emitted_next < total_q) ||
                          (pos_next[nsrc_pkg::PosW-1:8] != idx_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= nsrc_pkg::StepReset;
      width_q <= 1'b1;
      total_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nsrc_pkg::RegStepIncrement: step_q  <= cfg_data_i[nsrc_pkg::StepW-1:0];
        nsrc_pkg::RegSampleWidth:   width_q <= cfg_data_i[0];
        nsrc_pkg::RegOutputTotal:   total_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      idx_q     <= '0;
      emitted_q <= '0;
      chunk_q   <= '0;
      run_q     <= '0;
    end else begin
      if (cmd_i.accept) begin
        run_q <= '0;
        if (start_of_sound_i) begin
          pos_q     <= '0;
          idx_q     <= '0;
          emitted_q <= '0;
          chunk_q   <= '0;
        end
      end
      if (cmd_i.emit) begin
        pos_q     <= pos_next;
        emitted_q <= emitted_next;
        run_q     <= run_q + nsrc_pkg::RunCntW'(1);
        chunk_q   <= (chunk_q == ChunkLast) ? '0 : chunk_q + ChunkW'(1);
      end
      if (cmd_i.finish) begin
        idx_q <= idx_q + nsrc_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_conv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_sample_q <= sample_q;
      out_start_q  <= (chunk_q == '0);
      out_offset_q <= chunk_wide[nsrc_pkg::OffsetW-1:0];
      out_last_q   <= sts_o.run_last;
      out_done_q   <= (emitted_next == total_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = out_sample_q;
  assign chunk_start_o  = out_start_q;
  assign chunk_offset_o = out_offset_q;
  assign run_last_o     = out_last_q;
  assign sound_done_o   = out_done_q;

endmodule

// ----- rtl/nearest_sample_rate_converter_unit.sv -----
// Top level of the nearest sample rate converter.
// Instantiates nsrc_ctrl and nsrc_datapath; uses nsrc_pkg for shared types.
//
//   channel   direction  handshake                payload
//   in        sink       in_valid_i / in_stall_o   sample_raw_i, start_of_sound_i
//   out       source     out_valid_o / out_stall_i sample_out_o, chunk_start_o,
//                                                  chunk_offset_o, run_last_o,
//                                                  sound_done_o
//   cfg       sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// An input is accepted in the idle state and then emits each output it causes in the run state,
// or, when it causes none, just finishes there; no new input is taken until then.
// The controller makes one output per cycle while the output register is free.
// A stalled output holds the emit loop until the output register frees up.
// Reset is asynchronous and active low and restores the register defaults.
module nearest_sample_rate_converter_unit #(
  parameter int unsigned CHUNK_SIZE = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [nsrc_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [nsrc_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [nsrc_pkg::SampleW-1:0]        sample_raw_i,
  input  logic                                start_of_sound_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [nsrc_pkg::SampleW-1:0] sample_out_o,
  output logic                                chunk_start_o,
  output logic [nsrc_pkg::OffsetW-1:0]        chunk_offset_o,
  output logic                                run_last_o,
  output logic                                sound_done_o
);

  nsrc_pkg::cmd_t cmd;
  nsrc_pkg::sts_t sts;

  nsrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nsrc_datapath #(
    .CHUNK_SIZE (CHUNK_SIZE)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .sample_raw_i     (sample_raw_i),
    .start_of_sound_i (start_of_sound_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_out_o     (sample_out_o),
    .chunk_start_o    (chunk_start_o),
    .chunk_offset_o   (chunk_offset_o),
    .run_last_o       (run_last_o),
    .sound_done_o     (sound_done_o)
  );

endmodule

// ----- rtl/nsrc_checker.sv -----
// Port-level checker for the nearest sample rate converter.
// Depends on nsrc_pkg for widths; bound to nearest_sample_rate_converter_unit.
module nsrc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [nsrc_pkg::SampleW-1:0] sample_out_o,
  input logic                                chunk_start_o,
  input logic [nsrc_pkg::OffsetW-1:0]        chunk_offset_o,
  input logic                                run_last_o,
  input logic                                sound_done_o
);

  // A stalled result keeps its valid and its sample.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled output changed");

  // After an input transfer the block works on it before taking another.
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while the previous one is in work");

  // A chunk start always carries offset zero.
  a_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chunk_start_o |-> chunk_offset_o == '0)
    else $error("chunk start with nonzero offset");

  // The final output of a sound also ends the run of its input.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sound_done_o |-> run_last_o)
    else $error("sound done without run last");

endmodule

bind nearest_sample_rate_converter_unit nsrc_checker u_nsrc_checker (.*);
